// File: rtl/core/segment_tree_range_sum_defines.svh
// ----------------------------------------------------------------------------
// segment_tree_range_sum_defines.svh
// Assertion macros shared by the segment tree RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SEGTR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment tree check failed");

// Next-cycle implication, disabled during reset.
`define SEGTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment tree check failed");

`endif

// File: rtl/core/segtr_pkg.sv
// ----------------------------------------------------------------------------
// segtr_pkg
// Fixed widths, codes and controller state type for the segment tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package segtr_pkg;

  // Field widths
  localparam int POS_W   = 11;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 48;
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 2;

  // Register map
  localparam logic [PADDR_W-1:0] REG_SIZE_IN_USE = 2'd0;
  localparam logic [POS_W-1:0]   SIZE_RESET      = 11'd1024;

  // Operation codes
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Controller states
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_U_RD  = 6'b000100,
    ST_U_WR  = 6'b001000,
    ST_Q_A   = 6'b010000,
    ST_Q_B   = 6'b100000
  } segtr_state_t;

endpackage

// File: rtl/core/segtr_ram.sv
// ----------------------------------------------------------------------------
// segtr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segtr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/segtr_cfg.sv
// ----------------------------------------------------------------------------
// segtr_cfg
// APB register slave holding the size_in_use register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segtr_cfg
  import segtr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [POS_W-1:0]   size_in_use
);

  logic wr_xfer;

  // Access phase of a write transfer; no wait states
  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (wr_xfer && paddr == REG_SIZE_IN_USE) begin
      size_in_use <= pwdata[POS_W-1:0];
    end
  end

  // Read back
  assign prdata = (paddr == REG_SIZE_IN_USE) ? APB_DW'(size_in_use) : '0;

endmodule

// File: rtl/core/segtr_ctrl.sv
// ----------------------------------------------------------------------------
// segtr_ctrl
// Tree walker: clears the node store, runs leaf-to-root updates and
// bottom-up range sums with one read and one write per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segtr_ctrl
  import segtr_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        kind,
  input  logic [POS_W-1:0]            position,
  input  logic [VAL_W-1:0]            value,
  input  logic [POS_W-1:0]            range_low,
  input  logic [POS_W-1:0]            range_high,
  input  logic [POS_W-1:0]            size_in_use,
  output logic                        busy,
  output logic                        done,
  output logic [SUM_W-1:0]            range_total,
  output logic                        out_of_range,
  output logic                        mem_we,
  output logic [$clog2(LEAVES):0]     mem_waddr,
  output logic [SUM_W-1:0]            mem_wdata,
  output logic [$clog2(LEAVES):0]     mem_raddr,
  input  logic [SUM_W-1:0]            mem_rdata
);

  // Node index width (nodes 0..2*LEAVES-1) and walk bound width (up to 2*LEAVES)
  localparam int NW = $clog2(LEAVES) + 1;
  localparam int IW = NW + 1;
  localparam logic [IW-1:0] LEAF_BASE = IW'(LEAVES);
  localparam logic [NW-1:0] LAST_NODE = NW'(2 * LEAVES - 1);
  localparam logic [31:0]   LEAVES_U  = 32'(LEAVES);

  segtr_state_t   state;
  logic [NW-1:0]  clr_cnt;
  logic [NW-1:0]  node;
  logic [NW-1:0]  parent;
  logic [NW-1:0]  leaf_idx;
  logic [SUM_W-1:0] cur;
  logic [SUM_W-1:0] sum_up;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_sum;
  logic           rd_pend;
  logic [IW-1:0]  a;
  logic [IW-1:0]  b;
  logic [IW-1:0]  b_dec;
  logic [IW-1:0]  a_start;
  logic [IW-1:0]  b_start;
  logic           accept;
  logic           upd_ok;
  logic           lo_ok;
  logic           hi_ok;

  // 1..min(size_in_use, LEAVES)
  function automatic logic pos_ok(input logic [POS_W-1:0] p,
                                  input logic [POS_W-1:0] sz);
    return (p != '0) && (p <= sz) && (32'(p) <= LEAVES_U);
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign upd_ok = pos_ok(position, size_in_use);
  assign lo_ok  = pos_ok(range_low, size_in_use);
  assign hi_ok  = pos_ok(range_high, size_in_use);

  // Leaf and half-open walk bounds
  assign leaf_idx = NW'(LEAF_BASE + IW'(position) - IW'(1));
  assign a_start  = LEAF_BASE + IW'(range_low) - IW'(1);
  assign b_start  = LEAF_BASE + IW'(range_high);
  assign b_dec    = b - IW'(1);
  assign parent   = node >> 1;

  // Parent sum from the running child sum and its sibling
  assign sum_up  = cur + mem_rdata;
  // Fold in the node read issued last cycle
  assign acc_sum = rd_pend ? (acc + mem_rdata) : acc;

  // Memory port steering; a write always lands before any later read of it
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      ST_IDLE: begin
        if (accept && kind == KIND_UPDATE && upd_ok) begin
          mem_we    = 1'b1;
          mem_waddr = leaf_idx;
          mem_wdata = SUM_W'(value);
        end
      end
      ST_U_RD: begin
        mem_raddr = node ^ NW'(1);
      end
      ST_U_WR: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = sum_up;
      end
      ST_Q_A: begin
        mem_raddr = a[NW-1:0];
      end
      ST_Q_B: begin
        mem_raddr = b_dec[NW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        // Zero every node, one per cycle
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (clr_cnt == LAST_NODE) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_UPDATE) begin
              if (upd_ok) begin
                node  <= leaf_idx;
                cur   <= SUM_W'(value);
                state <= ST_U_RD;
              end else begin
                done         <= 1'b1;
                range_total  <= '0;
                out_of_range <= 1'b1;
              end
            end else if (!lo_ok || !hi_ok) begin
              done         <= 1'b1;
              range_total  <= '0;
              out_of_range <= 1'b1;
            end else if (range_low > range_high) begin
              done         <= 1'b1;
              range_total  <= '0;
              out_of_range <= 1'b0;
            end else begin
              a       <= a_start;
              b       <= b_start;
              acc     <= '0;
              rd_pend <= 1'b0;
              state   <= ST_Q_A;
            end
          end
        end

        // Update: sibling read, then parent write
        ST_U_RD: begin
          state <= ST_U_WR;
        end

        ST_U_WR: begin
          cur  <= sum_up;
          node <= parent;
          if (parent == NW'(1)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_U_RD;
          end
        end

        // Query: left bound step
        ST_Q_A: begin
          acc <= acc_sum;
          if (a >= b) begin
            done         <= 1'b1;
            range_total  <= acc_sum;
            out_of_range <= 1'b0;
            rd_pend      <= 1'b0;
            state        <= ST_IDLE;
          end else begin
            rd_pend <= a[0];
            if (a[0]) begin
              a <= a + IW'(1);
            end
            state <= ST_Q_B;
          end
        end

        // Query: right bound step, then climb one level
        ST_Q_B: begin
          acc     <= acc_sum;
          rd_pend <= b[0];
          a       <= a >> 1;
          b       <= b >> 1;
          state   <= ST_Q_A;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/segment_tree_range_sum.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// Point-update, range-sum segment tree over 1-based positions.
//
// Command channel: an operation transfers when start is high and busy is
// low. kind selects point update (position, value) or range sum query
// (range_low, range_high). A valid update gives no result; a query, or an
// update at a position outside 1..min(size_in_use, LEAVES), gives one
// result on range_total / out_of_range, marked by done for exactly one cycle.
// The receiver cannot stall; every result must be taken as it appears.
// An update writes the leaf, then a sibling read and a parent write per
// level up to the root; a query uses two read slots per level on the
// node RAM's single read port. Rejected and empty commands answer the
// next cycle.
// One operation is in flight at a time; busy stays high while it runs.
// Reset: size_in_use returns to 1024 and the node RAM is zeroed by a
// clearing pass over all 2*LEAVES nodes, busy high.
// The APB port writes size_in_use at address 0 with no wait states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_tree_range_sum_defines.svh"

module segment_tree_range_sum
  import segtr_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // Command and result
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [POS_W-1:0]   position,
  input  logic [VAL_W-1:0]   value,
  input  logic [POS_W-1:0]   range_low,
  input  logic [POS_W-1:0]   range_high,
  output logic               done,
  output logic [SUM_W-1:0]   range_total,
  output logic               out_of_range,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int NW = $clog2(LEAVES) + 1;

  logic [POS_W-1:0] size_in_use;
  logic             mem_we;
  logic [NW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic [NW-1:0]    mem_raddr;
  logic [SUM_W-1:0] mem_rdata;

  // Register slave
  segtr_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .size_in_use (size_in_use)
  );

  // Tree walker
  segtr_ctrl #(
    .LEAVES (LEAVES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .position     (position),
    .value        (value),
    .range_low    (range_low),
    .range_high   (range_high),
    .size_in_use  (size_in_use),
    .busy         (busy),
    .done         (done),
    .range_total  (range_total),
    .out_of_range (out_of_range),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Node sum store
  segtr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (2 * LEAVES)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Checks
  `SEGTR_ASSERT_NOW(a_done_has_cause, clk, rst, done, ($past(busy) || $past(start)))
  `SEGTR_ASSERT_NEXT(a_accept_progress, clk, rst, (start && !busy), (busy || done))
  `SEGTR_ASSERT_NOW(a_reject_zero, clk, rst, (done && out_of_range), (range_total == '0))

endmodule
